// File: rtl/attn_pkg.sv
// ----------------------------------------------------------------------------
// attn_pkg
// Shared types and constants of the attenuation log-log interpolator.
// ----------------------------------------------------------------------------
package attn_pkg;

  localparam int ENERGY_W = 25;
  localparam int COEF_W   = 40;
  localparam int FP_W     = 48;
  localparam int DIV_W    = 72;
  localparam int T_BITS   = 24;
  localparam int FP_SHIFT = 56;
  localparam int UNUM_W   = 14;
  localparam int UDEN_W   = 7;

  // configuration register indexes
  localparam logic [1:0] CFG_TABLE_LENGTH = 2'd0;
  localparam logic [1:0] CFG_DENSITY      = 2'd1;
  localparam logic [1:0] CFG_LENGTH_UNIT  = 2'd2;
  localparam logic [1:0] CFG_MAX_ENERGY   = 2'd3;

  localparam logic [23:0]         DENSITY_RESET    = 24'd65536;
  localparam logic [ENERGY_W-1:0] MAX_ENERGY_RESET = 25'd20000000;

  // length unit codes
  localparam logic [2:0] UNIT_CM   = 3'd0;
  localparam logic [2:0] UNIT_UM   = 3'd1;
  localparam logic [2:0] UNIT_MM   = 3'd2;
  localparam logic [2:0] UNIT_M    = 3'd3;
  localparam logic [2:0] UNIT_INCH = 3'd4;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [COEF_W-1:0]   atten;
    logic [COEF_W-1:0]   absorb;
  } attn_entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RD, S_CMP, S_RD_LO, S_LO, S_LOG_Q, S_LOG_0, S_LOG_1,
    S_TDIV, S_COEF, S_LOG_C0, S_LOG_C1, S_MUL_T, S_EXP, S_FP, S_MUL_AD,
    S_MUL_DEN, S_FDIV, S_OUT
  } attn_state_t;

  function automatic logic [UNUM_W-1:0] unit_num(input logic [2:0] code);
    logic [UNUM_W-1:0] r;
    unique case (code)
      UNIT_UM:   r = 14'd10000;
      UNIT_MM:   r = 14'd10;
      UNIT_M:    r = 14'd1;
      UNIT_INCH: r = 14'd50;
      default:   r = 14'd1;
    endcase
    return r;
  endfunction

  function automatic logic [UDEN_W-1:0] unit_den(input logic [2:0] code);
    logic [UDEN_W-1:0] r;
    unique case (code)
      UNIT_M:    r = 7'd100;
      UNIT_INCH: r = 7'd127;
      default:   r = 7'd1;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/attn_if.sv
// ----------------------------------------------------------------------------
// attn_if
// Item, result and configuration channels of the interpolator.
// ----------------------------------------------------------------------------
interface attn_item_if import attn_pkg::*;;
  logic                valid;
  logic                ready;
  logic                action;
  logic [6:0]          entry_index;
  logic [ENERGY_W-1:0] energy;
  logic [COEF_W-1:0]   load_mass_atten;
  logic [COEF_W-1:0]   load_energy_absorb;
  modport source (output valid, action, entry_index, energy, load_mass_atten,
                  load_energy_absorb, input ready);
  modport sink (input valid, action, entry_index, energy, load_mass_atten,
                load_energy_absorb, output ready);
endinterface

interface attn_result_if import attn_pkg::*;;
  logic              valid;
  logic              ready;
  logic              status;
  logic [COEF_W-1:0] mass_atten;
  logic [COEF_W-1:0] energy_absorb;
  logic [FP_W-1:0]   free_path;
  modport source (output valid, status, mass_atten, energy_absorb, free_path,
                  input ready);
  modport sink (input valid, status, mass_atten, energy_absorb, free_path,
                output ready);
endinterface

interface attn_cfg_if import attn_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          index;
  logic [ENERGY_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/attn_log2.sv
// ----------------------------------------------------------------------------
// attn_log2
// Iterative fixed-point log2: normalise, then one squaring per fraction bit.
// ----------------------------------------------------------------------------
module attn_log2 import attn_pkg::*; #(
  parameter int LOG_FRAC_BITS = 24,
  localparam int LW = LOG_FRAC_BITS + 6,
  localparam int KW = $clog2(LOG_FRAC_BITS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [COEF_W-1:0] x,
  output logic              done,
  output logic [LW-1:0]     result
);

  logic                     busy;
  logic                     norm;
  logic [COEF_W-1:0]        xn;
  logic [5:0]               p;
  logic [31:0]              m;
  logic [LOG_FRAC_BITS-1:0] frac;
  logic [KW-1:0]            k;
  logic [63:0]              sq;
  logic [32:0]              sqs;
  logic [31:0]              m_next;

  assign sq     = 64'(m) * 64'(m);
  assign sqs    = sq[63:31];
  assign m_next = sqs[32] ? sqs[32:1] : sqs[31:0];
  assign result = {p, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        norm <= 1'b1;
        xn   <= (x == '0) ? COEF_W'(1) : x;
        p    <= 6'd39;
        k    <= '0;
        frac <= '0;
      end else if (busy) begin
        if (norm) begin
          // coarse steps while the top byte is empty
          if (xn[COEF_W-1]) begin
            m    <= xn[COEF_W-1:COEF_W-32];
            norm <= 1'b0;
          end else if (xn[COEF_W-1:COEF_W-8] == '0) begin
            xn <= xn << 8;
            p  <= p - 6'd8;
          end else begin
            xn <= xn << 1;
            p  <= p - 6'd1;
          end
        end else begin
          m    <= m_next;
          frac <= {frac[LOG_FRAC_BITS-2:0], sqs[32]};
          k    <= k + 1'b1;
          if (k == KW'(LOG_FRAC_BITS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: rtl/attn_exp2.sv
// ----------------------------------------------------------------------------
// attn_exp2
// Iterative fixed-point exp2: nested integer square roots, one root bit a cycle.
// ----------------------------------------------------------------------------
module attn_exp2 import attn_pkg::*; #(
  parameter int LOG_FRAC_BITS = 24,
  localparam int LW = LOG_FRAC_BITS + 6,
  localparam int KW = $clog2(LOG_FRAC_BITS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [LW-1:0]     l,
  output logic              done,
  output logic [COEF_W-1:0] result
);

  logic                     busy;
  logic                     load_ph;
  logic                     fin;
  logic [LW-1:0]            lat;
  logic [KW-1:0]            k;
  logic [32:0]              r;
  logic [63:0]              v;
  logic [63:0]              res;
  logic [63:0]              bitr;
  logic [LOG_FRAC_BITS-1:0] f;
  logic [5:0]               ip;
  logic [32:0]              rr;
  logic [64:0]              sum;
  logic                     ge;
  logic [63:0]              res_next;
  logic [40:0]              wide;
  logic                     sat;

  assign f        = lat[LOG_FRAC_BITS-1:0];
  assign ip       = lat[LW-1:LOG_FRAC_BITS];
  assign rr       = f[k] ? (r << 1) : r;
  assign sum      = {1'b0, res} + {1'b0, bitr};
  assign ge       = {1'b0, v} >= sum;
  assign res_next = ge ? ((res >> 1) + bitr) : (res >> 1);

  always_comb begin
    sat  = 1'b0;
    wide = '0;
    if (ip >= 6'd40) begin
      sat = 1'b1;
    end else if (ip >= 6'd31) begin
      wide = 41'(r) << (ip - 6'd31);
      sat  = wide[40];
    end else begin
      wide = 41'(r >> (6'd31 - ip));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        load_ph <= 1'b1;
        k       <= '0;
        r       <= 33'h080000000;
        lat     <= l;
      end else if (fin) begin
        result <= sat ? {COEF_W{1'b1}} : wide[COEF_W-1:0];
        done   <= 1'b1;
      end else if (busy) begin
        if (load_ph) begin
          v       <= 64'(rr) << 31;
          res     <= '0;
          bitr    <= 64'h4000000000000000;
          load_ph <= 1'b0;
        end else begin
          if (ge) v <= v - sum[63:0];
          res  <= res_next;
          bitr <= bitr >> 2;
          if (bitr[0]) begin
            r <= res_next[32:0];
            k <= k + 1'b1;
            if (k == KW'(LOG_FRAC_BITS - 1)) begin
              busy <= 1'b0;
              fin  <= 1'b1;
            end else begin
              load_ph <= 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

// File: rtl/attn_div.sv
// ----------------------------------------------------------------------------
// attn_div
// Restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module attn_div import attn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  logic             busy;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [6:0]       cnt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign trial = {rem, quo[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= num;
        dvs  <= den;
        cnt  <= '0;
      end else if (busy) begin
        rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt + 7'd1;
        if (cnt == 7'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/attenuation_loglog_interpolator.sv
// ----------------------------------------------------------------------------
// attenuation_loglog_interpolator
// Photon attenuation table with log-log interpolation and mean free path.
// ----------------------------------------------------------------------------
// items carries load items (action 0: write one table entry) and query items
// (action 1: look up an energy). Every item gives one item on results. cfg
// writes table_length, density, length_unit and max_energy; it is always ready.
// A query scans the table entry by entry, then runs up to seven log2 passes, a
// divider for the weight, up to two exp2 passes and a divider for the free path.
// Items are handled one at a time; items.ready is high only between items. A
// finished result sits in the output register while the next item is taken; a
// stalled receiver holds the block in its last step until the register frees.
// Reset restores the configuration defaults and empties the output register;
// the table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module attenuation_loglog_interpolator import attn_pkg::*; #(
  parameter int TABLE_DEPTH   = 128,
  parameter int LOG_FRAC_BITS = 24
) (
  input  logic           clk,
  input  logic           rst,
  attn_item_if.sink      items,
  attn_result_if.source  results,
  attn_cfg_if.sink       cfg
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = (CW > 8) ? CW : 8;
  localparam int LW = LOG_FRAC_BITS + 6;
  localparam int PW = LW + T_BITS + 1;

  attn_state_t state, state_next;

  // configuration
  logic [7:0]          table_length;
  logic [23:0]         density;
  logic [2:0]          length_unit;
  logic [ENERGY_W-1:0] max_energy;

  attn_entry_t mem [TABLE_DEPTH];
  attn_entry_t rdata;
  logic [AW-1:0] raddr;
  logic          wr_en;

  logic [ENERGY_W-1:0] en;
  logic [CW-1:0]       i;
  logic [CW-1:0]       n;
  attn_entry_t         lo;
  attn_entry_t         hi;
  logic [LW-1:0]       le, le0, le1, la0, la1;
  logic [T_BITS:0]     t;
  logic                sel;
  logic                go;
  logic [PW-1:0]       prod_t;
  logic [63:0]         prod_ad;
  logic [DIV_W-1:0]    dvs;
  logic                status;
  logic [COEF_W-1:0]   a_res, b_res;
  logic [FP_W-1:0]     fp;
  logic                out_valid;

  logic                log_start, log_done, exp_start, exp_done, div_start, div_done;
  logic [COEF_W-1:0]   log_x;
  logic [LW-1:0]       log_res, exp_in;
  logic [COEF_W-1:0]   exp_res;
  logic [DIV_W-1:0]    div_num, div_den, div_quo;
  logic [LW-1:0]       numl, denl, numc, diff_c;
  logic [COEF_W-1:0]   c0, c1;
  logic                up;
  logic                out_free;
  logic                item_acc;

  assign n = (NW'(table_length) > NW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(table_length);
  assign numl   = (le > le0) ? (le - le0) : '0;
  assign denl   = (le1 > le0) ? (le1 - le0) : '0;
  assign numc   = (numl > denl) ? denl : numl;
  assign c0     = sel ? lo.absorb : lo.atten;
  assign c1     = sel ? hi.absorb : hi.atten;
  assign up     = la1 >= la0;
  assign diff_c = up ? (la1 - la0) : (la0 - la1);
  assign exp_in = up ? (la0 + LW'(prod_t >> T_BITS)) : (la0 - LW'(prod_t >> T_BITS));
  assign out_free = !out_valid || results.ready;
  assign item_acc = items.valid && items.ready;
  assign wr_en = item_acc && (items.action == ACT_LOAD)
                 && ({25'd0, items.entry_index} < 32'(TABLE_DEPTH));

  attn_log2 #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log (
    .clk(clk), .rst(rst), .start(log_start), .x(log_x), .done(log_done), .result(log_res)
  );

  attn_exp2 #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_exp (
    .clk(clk), .rst(rst), .start(exp_start), .l(exp_in), .done(exp_done), .result(exp_res)
  );

  attn_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(items.entry_index)] <= '{energy: items.energy,
                                       atten: items.load_mass_atten,
                                       absorb: items.load_energy_absorb};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= '0;
      density      <= DENSITY_RESET;
      length_unit  <= UNIT_CM;
      max_energy   <= MAX_ENERGY_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_TABLE_LENGTH: table_length <= cfg.data[7:0];
        CFG_DENSITY:      density      <= cfg.data[23:0];
        CFG_LENGTH_UNIT:  length_unit  <= cfg.data[2:0];
        CFG_MAX_ENERGY:   max_energy   <= cfg.data;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (item_acc) state_next = (items.action == ACT_LOAD) ? S_OUT : S_CHECK;
      S_CHECK:   state_next = (n == '0 || en > max_energy) ? S_OUT : S_RD;
      S_RD:      state_next = S_CMP;
      S_CMP: begin
        if (rdata.energy >= en) begin
          if (i == '0) state_next = S_FP;
          else state_next = S_RD_LO;
          if (i == '0 && rdata.energy != en) state_next = S_OUT;
        end else begin
          state_next = (i + 1'b1 == n) ? S_OUT : S_RD;
        end
      end
      S_RD_LO:   state_next = S_LO;
      S_LO:      state_next = S_LOG_Q;
      S_LOG_Q:   if (log_done) state_next = S_LOG_0;
      S_LOG_0:   if (log_done) state_next = S_LOG_1;
      S_LOG_1:   if (log_done) state_next = S_TDIV;
      S_TDIV:    if (denl == '0 || div_done) state_next = S_COEF;
      S_COEF: begin
        if (c0 == '0 || c1 == '0) state_next = sel ? S_FP : S_COEF;
        else state_next = S_LOG_C0;
      end
      S_LOG_C0:  if (log_done) state_next = S_LOG_C1;
      S_LOG_C1:  if (log_done) state_next = S_MUL_T;
      S_MUL_T:   state_next = S_EXP;
      S_EXP:     if (exp_done) state_next = sel ? S_FP : S_COEF;
      S_FP:      state_next = (a_res == '0 || density == '0) ? S_OUT : S_MUL_AD;
      S_MUL_AD:  state_next = S_MUL_DEN;
      S_MUL_DEN: state_next = S_FDIV;
      S_FDIV:    if (div_done) state_next = S_OUT;
      S_OUT:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    items.ready = (state == S_IDLE);
    cfg.ready   = 1'b1;
    raddr       = i[AW-1:0];
    log_start   = 1'b0;
    exp_start   = 1'b0;
    div_start   = 1'b0;
    log_x       = COEF_W'(en);
    div_num     = DIV_W'(numc) << T_BITS;
    div_den     = DIV_W'(denl);
    unique case (state)
      S_RD_LO:   raddr = AW'(i - 1'b1);
      S_LOG_Q:   log_start = !go;
      S_LOG_0: begin
        log_start = !go;
        log_x     = COEF_W'(lo.energy);
      end
      S_LOG_1: begin
        log_start = !go;
        log_x     = COEF_W'(hi.energy);
      end
      S_TDIV:    div_start = !go && (denl != '0);
      S_LOG_C0: begin
        log_start = !go;
        log_x     = c0;
      end
      S_LOG_C1: begin
        log_start = !go;
        log_x     = c1;
      end
      S_EXP:     exp_start = !go;
      S_FDIV: begin
        div_start = !go;
        div_num   = DIV_W'(unit_num(length_unit)) << FP_SHIFT;
        div_den   = dvs;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      go        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      go    <= (go || log_start || exp_start || div_start)
               && !(log_done || exp_done || div_done);
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (results.valid && results.ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        en     <= items.energy;
        status <= 1'b0;
        a_res  <= '0;
        b_res  <= '0;
        fp     <= '0;
        i      <= '0;
        sel    <= 1'b0;
      end
      S_CHECK:   if (n == '0 || en > max_energy) status <= 1'b1;
      S_CMP: begin
        hi <= rdata;
        if (rdata.energy >= en) begin
          if (i == '0 && rdata.energy != en) begin
            status <= 1'b1;
            a_res  <= '0;
            b_res  <= '0;
          end else begin
            a_res <= rdata.atten;
            b_res <= rdata.absorb;
          end
        end else begin
          i <= i + 1'b1;
          if (i + 1'b1 == n) status <= 1'b1;
        end
      end
      S_LO:      lo <= rdata;
      S_LOG_Q:   if (log_done) le <= log_res;
      S_LOG_0:   if (log_done) le0 <= log_res;
      S_LOG_1: begin
        if (log_done) le1 <= log_res;
        t <= '0;
      end
      S_TDIV:    if (div_done) t <= div_quo[T_BITS:0];
      S_COEF: begin
        // a zero end point gives a zero coefficient
        if (c0 == '0 || c1 == '0) begin
          if (sel) b_res <= '0;
          else a_res <= '0;
          sel <= 1'b1;
        end
      end
      S_LOG_C0:  if (log_done) la0 <= log_res;
      S_LOG_C1:  if (log_done) la1 <= log_res;
      S_MUL_T:   prod_t <= PW'(diff_c) * PW'(t);
      S_EXP: begin
        if (exp_done) begin
          if (sel) b_res <= exp_res;
          else a_res <= exp_res;
          sel <= 1'b1;
        end
      end
      S_FP:      if (a_res == '0 || density == '0) fp <= {FP_W{1'b1}};
      S_MUL_AD:  prod_ad <= 64'(a_res) * 64'(density);
      S_MUL_DEN: dvs <= DIV_W'(prod_ad) * DIV_W'(unit_den(length_unit));
      S_FDIV: begin
        if (div_done) begin
          fp <= (div_quo[DIV_W-1:FP_W] != '0) ? {FP_W{1'b1}} : div_quo[FP_W-1:0];
        end
      end
      S_OUT: begin
        if (out_free) begin
          results.status        <= status;
          results.mass_atten    <= a_res;
          results.energy_absorb <= b_res;
          results.free_path     <= fp;
        end
      end
      default: ;
    endcase
  end

  assign results.valid = out_valid;

endmodule
